// ----- rtl/hsfd_pkg.sv -----
package hsfd_pkg;

    typedef logic [1:0] status_t;
    typedef logic [2:0] pos_t;

    localparam status_t STATUS_OK       = 2'd0;
    localparam status_t STATUS_TEMP_CRC = 2'd1;
    localparam status_t STATUS_HUM_CRC  = 2'd2;

    localparam pos_t POS_T_HI  = 3'd0;
    localparam pos_t POS_T_LO  = 3'd1;
    localparam pos_t POS_T_CRC = 3'd2;
    localparam pos_t POS_H_HI  = 3'd3;
    localparam pos_t POS_H_LO  = 3'd4;
    localparam pos_t POS_H_CRC = 3'd5;

    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_MSB  = 8'h80;

    // 175000 = 2 * 65535 + 43930, 100000 = 65535 + 34465
    localparam logic [15:0] TEMP_FRAC_MULT = 16'd43930;
    localparam logic [15:0] HUM_FRAC_MULT  = 16'd34465;
    localparam logic [15:0] FULL_SCALE     = 16'd65535;
    localparam logic [17:0] TEMP_OFFSET_MAG = 18'd45000;
    localparam logic [16:0] HUM_MAX_MPCT   = 17'd100000;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++)
        begin
            if ((c & CRC_MSB) != 8'd0)
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

    // exact floor(y / 65535) for y below 65535 * 65535
    function automatic logic [15:0] div_full_scale(input logic [31:0] y);
        logic [15:0] q0;
        logic [16:0] r;
        q0 = y[31:16];
        r  = {1'b0, y[15:0]} + {1'b0, q0};
        return (r >= {1'b0, FULL_SCALE}) ? q0 + 16'd1 : q0;
    endfunction

endpackage

// ----- rtl/humidity_sensor_frame_decoder.sv -----
// Decodes the six-byte measurement response (temperature word, CRC, humidity word, CRC)
// one byte per transfer and takes a new byte every cycle while rx_stall is low. Each
// word is checked with CRC-8 (poly 0x31, init 0xFF); after the sixth byte one result
// carries the status and the converted temperature (milli-degrees C) and humidity
// (milli-percent), both zero on a CRC error, with the temperature CRC reported first.
// frame_first forces a byte to be taken as the first of a new response. A byte goes
// through an input register and the conversion is done on its way into the result
// register. rx_stall rises only while a finished result waits on result_stall and the
// next response's last byte is already held.
module humidity_sensor_frame_decoder
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   rx_valid,
    output logic                   rx_stall,
    input  logic [7:0]             rx_byte,
    input  logic                   frame_first,
    output logic                   result_valid,
    input  logic                   result_stall,
    output hsfd_pkg::status_t      status,
    output logic signed [17:0]     temperature_mc,
    output logic [16:0]            humidity_mpct
);
    import hsfd_pkg::*;

    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_first_reg;

    pos_t        pos_reg;
    logic [7:0]  crc_reg;
    logic [15:0] temp_word_reg;
    logic [7:0]  hum_hi_reg;
    logic [7:0]  hum_lo_reg;
    logic        temp_good_reg;

    logic        result_valid_reg;
    status_t     status_reg;
    logic [17:0] temp_reg;
    logic [16:0] hum_reg;

    pos_t        s1_pos;
    logic        is_last;
    logic        s1_adv;
    logic [7:0]  crc_in;
    logic [7:0]  crc_out;
    pos_t        pos_next;

    logic [15:0] hum_raw;
    logic [31:0] temp_prod;
    logic [31:0] hum_prod;
    logic [15:0] temp_q;
    logic [15:0] hum_q;
    logic [17:0] temp_val;
    logic [16:0] hum_sum;
    logic [16:0] hum_val;
    status_t     status_next;

    // byte position of the held byte
    always_comb
    begin
        if (s1_first_reg)
            s1_pos = POS_T_HI;
        else if (pos_reg > POS_H_CRC)
            s1_pos = POS_T_HI;
        else
            s1_pos = pos_reg;
    end

    assign is_last  = (s1_pos == POS_H_CRC);
    assign s1_adv   = s1_valid_reg && !(is_last && result_valid_reg && result_stall);
    assign rx_stall = s1_valid_reg && !s1_adv;
    assign pos_next = is_last ? POS_T_HI : s1_pos + 3'd1;

    assign crc_in  = (s1_pos == POS_T_HI || s1_pos == POS_H_HI) ? CRC_INIT : crc_reg;
    assign crc_out = crc8_byte(crc_in, s1_byte_reg);

    // conversions
    assign hum_raw   = {hum_hi_reg, hum_lo_reg};
    assign temp_prod = 32'(temp_word_reg) * 32'(TEMP_FRAC_MULT);
    assign hum_prod  = 32'(hum_raw) * 32'(HUM_FRAC_MULT);
    assign temp_q    = div_full_scale(temp_prod);
    assign hum_q     = div_full_scale(hum_prod);
    assign temp_val  = {1'b0, temp_word_reg, 1'b0} + 18'(temp_q) - TEMP_OFFSET_MAG;
    assign hum_sum   = 17'(hum_raw) + 17'(hum_q);
    assign hum_val   = (hum_sum > HUM_MAX_MPCT) ? HUM_MAX_MPCT : hum_sum;

    always_comb
    begin
        if (!temp_good_reg)
            status_next = STATUS_TEMP_CRC;
        else if (crc_reg != s1_byte_reg)
            status_next = STATUS_HUM_CRC;
        else
            status_next = STATUS_OK;
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (!rx_stall)
            s1_valid_reg <= rx_valid;
    end

    always_ff @(posedge clk)
    begin
        if (rx_valid && !rx_stall)
        begin
            s1_byte_reg  <= rx_byte;
            s1_first_reg <= frame_first;
        end
    end

    // frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= POS_T_HI;
            crc_reg       <= CRC_INIT;
            temp_word_reg <= 16'd0;
            hum_hi_reg    <= 8'd0;
            hum_lo_reg    <= 8'd0;
            temp_good_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            pos_reg <= pos_next;
            case (s1_pos)
                POS_T_HI:
                begin
                    crc_reg       <= crc_out;
                    temp_word_reg <= {s1_byte_reg, 8'd0};
                end
                POS_T_LO:
                begin
                    crc_reg            <= crc_out;
                    temp_word_reg[7:0] <= s1_byte_reg;
                end
                POS_T_CRC:
                begin
                    temp_good_reg <= (crc_reg == s1_byte_reg);
                    crc_reg       <= CRC_INIT;
                end
                POS_H_HI:
                begin
                    crc_reg    <= crc_out;
                    hum_hi_reg <= s1_byte_reg;
                end
                POS_H_LO:
                begin
                    crc_reg    <= crc_out;
                    hum_lo_reg <= s1_byte_reg;
                end
                POS_H_CRC:
                begin
                    crc_reg <= CRC_INIT;
                end
                default:
                begin
                    crc_reg <= crc_reg;
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (s1_adv && is_last)
            result_valid_reg <= 1'b1;
        else if (!result_stall)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && is_last)
        begin
            status_reg <= status_next;
            if (status_next == STATUS_OK)
            begin
                temp_reg <= temp_val;
                hum_reg  <= hum_val;
            end
            else
            begin
                temp_reg <= 18'd0;
                hum_reg  <= 17'd0;
            end
        end
    end

    assign result_valid   = result_valid_reg;
    assign status         = status_reg;
    assign temperature_mc = $signed(temp_reg);
    assign humidity_mpct  = hum_reg;

    // error results carry zero values
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status != STATUS_OK) |->
        (temperature_mc == 18'sd0 && humidity_mpct == 17'd0))
        else $error("error result with nonzero values");

    // converted values stay in range
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status == STATUS_OK) |->
        (humidity_mpct <= HUM_MAX_MPCT && temperature_mc >= -18'sd45000))
        else $error("converted value out of range");

    // position never leaves the frame
    assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_H_CRC)
        else $error("byte position out of range");

    // a new result only follows a last byte moving on
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(s1_adv && is_last))
        else $error("result without a last byte");

endmodule
